[src/mbrv_pkg.sv]
`default_nettype none

package mbrv_pkg;

   localparam int MAX_FRAME_BYTES  = 256;
   localparam int BYTE_INDEX_WIDTH = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_WIDTH        = 9;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] OWN_ADDRESS_RESET = 8'd1;
   localparam logic [7:0] BROADCAST_ADDRESS = 8'd0;

   localparam logic [LEN_WIDTH-1:0] POS_ADDRESS  = LEN_WIDTH'(0);
   localparam logic [LEN_WIDTH-1:0] POS_FUNCTION = LEN_WIDTH'(1);
   localparam logic [LEN_WIDTH-1:0] POS_QTY_HI   = LEN_WIDTH'(4);
   localparam logic [LEN_WIDTH-1:0] POS_QTY_LO   = LEN_WIDTH'(5);
   localparam logic [LEN_WIDTH-1:0] POS_COUNT    = LEN_WIDTH'(6);

   localparam logic [LEN_WIDTH-1:0] FIXED_FRAME_LEN = LEN_WIDTH'(8);
   localparam logic [LEN_WIDTH-1:0] MULTI_FRAME_BASE = LEN_WIDTH'(9);
   localparam logic [LEN_WIDTH-1:0] MIN_TAIL_LEN = LEN_WIDTH'(3);

   localparam logic [15:0] COIL_ON       = 16'hFF00;
   localparam logic [15:0] COIL_OFF      = 16'h0000;
   localparam logic [15:0] MAX_BIT_QTY   = 16'd254;
   localparam logic [15:0] MAX_REG_QTY   = 16'd127;
   localparam logic [15:0] MAX_MULTI_REG = 16'd126;

   localparam logic [7:0] FC_LAST_FIXED  = 8'd6;
   localparam logic [7:0] FC_ZERO        = 8'd0;
   localparam logic [7:0] FC_READ_COILS  = 8'd1;
   localparam logic [7:0] FC_READ_INPUTS = 8'd2;
   localparam logic [7:0] FC_READ_HOLD   = 8'd3;
   localparam logic [7:0] FC_READ_INREG  = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FC_WRITE_REG   = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
   localparam logic [7:0] FC_USER       = 8'h41;

   localparam logic [2:0] CSR_OWN_ADDRESS = 3'd0;

   typedef enum logic [1:0] {
      VERDICT_ACCEPTED    = 2'd0,
      VERDICT_REJECTED    = 2'd1,
      VERDICT_UNSUPPORTED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } mbrv_req_type;

   typedef struct packed {
      verdict_type verdict;
      logic        addressed_here;
      logic [7:0]  function_code;
   } mbrv_rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // frame length implied by the header, zero if none
   function automatic logic [LEN_WIDTH-1:0] implied_length(input logic [7:0] func,
                                                           input logic [7:0] count);
      logic [LEN_WIDTH-1:0] len;
      len = '0;
      if (func <= FC_LAST_FIXED) begin
         len = FIXED_FRAME_LEN;
      end else if (func == FC_WRITE_COILS || func == FC_WRITE_REGS) begin
         len = MULTI_FRAME_BASE + LEN_WIDTH'(count);
      end
      return len;
   endfunction

endpackage

`default_nettype wire

[src/modbus_rtu_request_validator_core.sv]
// the frame-end byte passes the input register, then its result word loads the result register
// throughput: one byte per cycle unless stalled; input and result registers are each one stage
// the input register stalls only when a frame-end byte meets a held result word
// reset (synchronous, active high) clears frame state and sets own address to 1
`default_nettype none

module modbus_rtu_request_validator_core
   import mbrv_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire mbrv_req_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      mbrv_rsp_type rsp_data,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output      logic [31:0]  csr_prdata,
   output      logic         csr_pready
);

   logic [7:0] own_address_ff;

   logic         s1_valid_ff, s1_valid_in;
   mbrv_req_type s1_word_ff;

   logic [BYTE_INDEX_WIDTH-1:0] byte_index_ff, byte_index_in;
   logic        overlong_ff, overlong_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] crc_history_ff, crc_history_in;
   logic [7:0]  recent_byte_ff, recent_byte_in;
   logic [7:0]  address_byte_ff, address_byte_in;
   logic [7:0]  func_byte_ff, func_byte_in;
   logic [15:0] quantity_word_ff, quantity_word_in;
   logic [7:0]  count_byte_ff, count_byte_in;
   logic [15:0] crc_at_expected_ff, crc_at_expected_in;
   logic [7:0]  crc_lo_seen_ff, crc_lo_seen_in;
   logic        crc_match_ff, crc_match_in;

   logic         rsp_valid_ff, rsp_valid_in;
   mbrv_rsp_type rsp_data_ff, rsp_data_in;

   logic                        stall;
   logic                        go;
   logic                        store;
   logic [7:0]                  b;
   logic [LEN_WIDTH-1:0]        idx;
   logic [LEN_WIDTH-1:0]        exp_len;
   logic [LEN_WIDTH-1:0]        len;
   logic [BYTE_INDEX_WIDTH-1:0] index_next;
   logic [7:0]                  addr_n, func_n, count_n;
   logic [15:0]                 qty_n, crc_at_n;
   logic [7:0]                  crc_lo_n;
   logic                        match_n;
   logic                        tail_ok;
   logic                        ok;
   logic                        unsupported;
   verdict_type                 verdict;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_OWN_ADDRESS[2]) ? {24'h000000, own_address_ff}
                                                            : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDRESS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == CSR_OWN_ADDRESS[2]) begin
         own_address_ff <= csr_pwdata[7:0];
      end
   end

   // input register
   assign stall       = s1_valid_ff && s1_word_ff.frame_end && rsp_valid_ff && rsp_stall;
   assign req_stall   = stall;
   assign go          = s1_valid_ff && !stall;
   assign s1_valid_in = stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !stall) begin
         s1_word_ff <= req_data;
      end
   end

   // frame state update
   always_comb begin
      b     = s1_word_ff.rx_byte;
      idx   = LEN_WIDTH'(byte_index_ff);
      store = !overlong_ff && (byte_index_ff < BYTE_INDEX_WIDTH'(MAX_FRAME_BYTES));

      addr_n   = address_byte_ff;
      func_n   = func_byte_ff;
      qty_n    = quantity_word_ff;
      count_n  = count_byte_ff;
      crc_at_n = crc_at_expected_ff;
      crc_lo_n = crc_lo_seen_ff;
      match_n  = crc_match_ff;
      tail_ok  = 1'b0;
      index_next = byte_index_ff;

      if (store) begin
         if (idx == POS_ADDRESS) begin
            addr_n = b;
         end
         if (idx == POS_FUNCTION) begin
            func_n = b;
         end
         if (idx == POS_QTY_HI) begin
            qty_n[15:8] = b;
         end
         if (idx == POS_QTY_LO) begin
            qty_n[7:0] = b;
         end
         if (idx == POS_COUNT) begin
            count_n = b;
         end
      end

      exp_len = implied_length(func_n, count_n);

      if (store) begin
         if (exp_len != '0) begin
            if (idx == exp_len - LEN_WIDTH'(2)) begin
               crc_at_n = running_crc_ff;
               crc_lo_n = b;
            end else if (idx == exp_len - LEN_WIDTH'(1)) begin
               match_n = (crc_at_expected_ff == {b, crc_lo_seen_ff});
            end
         end
         tail_ok    = (crc_history_ff == {b, recent_byte_ff});
         index_next = byte_index_ff + BYTE_INDEX_WIDTH'(1);
      end

      len = LEN_WIDTH'(index_next);
      ok  = (exp_len != '0) && (len >= exp_len) && match_n;
      unsupported = 1'b0;
      case (func_n)
         FC_ZERO, FC_READ_COILS, FC_READ_INPUTS: begin
            ok = ok && (qty_n < MAX_BIT_QTY);
         end
         FC_READ_HOLD, FC_READ_INREG: begin
            ok = ok && (qty_n < MAX_REG_QTY);
         end
         FC_WRITE_COIL: begin
            ok = ok && (qty_n == COIL_ON || qty_n == COIL_OFF);
         end
         FC_WRITE_REG: begin
            ok = ok;
         end
         FC_WRITE_COILS: begin
            ok = ok && (count_n != 8'h00) && (qty_n != 16'h0000);
         end
         FC_WRITE_REGS: begin
            ok = ok && (qty_n != 16'h0000) && (qty_n < MAX_MULTI_REG) &&
                 ({8'h00, count_n} == {qty_n[14:0], 1'b0});
         end
         FC_USER: begin
            ok = (len >= MIN_TAIL_LEN) && tail_ok;
         end
         default: begin
            ok          = 1'b0;
            unsupported = 1'b1;
         end
      endcase

      if (!store) begin
         verdict = VERDICT_REJECTED;
      end else if (unsupported) begin
         verdict = VERDICT_UNSUPPORTED;
      end else if (ok) begin
         verdict = VERDICT_ACCEPTED;
      end else begin
         verdict = VERDICT_REJECTED;
      end

      rsp_data_in.verdict        = verdict;
      rsp_data_in.addressed_here = (addr_n == own_address_ff) || (addr_n == BROADCAST_ADDRESS);
      rsp_data_in.function_code  = func_n;
   end

   always_comb begin
      byte_index_in      = byte_index_ff;
      overlong_in        = overlong_ff;
      running_crc_in     = running_crc_ff;
      crc_history_in     = crc_history_ff;
      recent_byte_in     = recent_byte_ff;
      address_byte_in    = address_byte_ff;
      func_byte_in       = func_byte_ff;
      quantity_word_in   = quantity_word_ff;
      count_byte_in      = count_byte_ff;
      crc_at_expected_in = crc_at_expected_ff;
      crc_lo_seen_in     = crc_lo_seen_ff;
      crc_match_in       = crc_match_ff;
      if (go) begin
         if (s1_word_ff.frame_end) begin
            byte_index_in      = '0;
            overlong_in        = 1'b0;
            running_crc_in     = CRC_INIT;
            crc_history_in     = CRC_INIT;
            recent_byte_in     = 8'h00;
            address_byte_in    = 8'h00;
            func_byte_in       = 8'h00;
            quantity_word_in   = 16'h0000;
            count_byte_in      = 8'h00;
            crc_at_expected_in = 16'h0000;
            crc_lo_seen_in     = 8'h00;
            crc_match_in       = 1'b0;
         end else if (store) begin
            byte_index_in      = index_next;
            running_crc_in     = crc_feed(running_crc_ff, b);
            crc_history_in     = running_crc_ff;
            recent_byte_in     = b;
            address_byte_in    = addr_n;
            func_byte_in       = func_n;
            quantity_word_in   = qty_n;
            count_byte_in      = count_n;
            crc_at_expected_in = crc_at_n;
            crc_lo_seen_in     = crc_lo_n;
            crc_match_in       = match_n;
         end else begin
            overlong_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff      <= '0;
         overlong_ff        <= 1'b0;
         running_crc_ff     <= CRC_INIT;
         crc_history_ff     <= CRC_INIT;
         recent_byte_ff     <= 8'h00;
         address_byte_ff    <= 8'h00;
         func_byte_ff       <= 8'h00;
         quantity_word_ff   <= 16'h0000;
         count_byte_ff      <= 8'h00;
         crc_at_expected_ff <= 16'h0000;
         crc_lo_seen_ff     <= 8'h00;
         crc_match_ff       <= 1'b0;
      end else begin
         byte_index_ff      <= byte_index_in;
         overlong_ff        <= overlong_in;
         running_crc_ff     <= running_crc_in;
         crc_history_ff     <= crc_history_in;
         recent_byte_ff     <= recent_byte_in;
         address_byte_ff    <= address_byte_in;
         func_byte_ff       <= func_byte_in;
         quantity_word_ff   <= quantity_word_in;
         count_byte_ff      <= count_byte_in;
         crc_at_expected_ff <= crc_at_expected_in;
         crc_lo_seen_ff     <= crc_lo_seen_in;
         crc_match_ff       <= crc_match_in;
      end
   end

   // result register
   assign rsp_valid_in = (go && s1_word_ff.frame_end) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && s1_word_ff.frame_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= BYTE_INDEX_WIDTH'(MAX_FRAME_BYTES))
      else $error("byte index past frame limit");

   a_overlong_full: assert property (@(posedge clock) disable iff (reset)
      overlong_ff |-> byte_index_ff == BYTE_INDEX_WIDTH'(MAX_FRAME_BYTES))
      else $error("overlong flag without a full frame");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      go && s1_word_ff.frame_end |=> rsp_valid_ff)
      else $error("frame end gave no result word");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      go && s1_word_ff.frame_end |=> byte_index_ff == '0 && !overlong_ff &&
                                     running_crc_ff == CRC_INIT)
      else $error("frame state not cleared after frame end");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("held input word lost");
`endif

endmodule

`default_nettype wire
